/* sv/tpc_pkg.sv */
// Shared types, microcode table and fixed-point helpers for the translational predictor-corrector.
package tpc_pkg;

	localparam int DW = 64;
	localparam int AXES = 3;
	localparam int PC_W = 5;
	localparam int IN_W = 4 * DW;
	localparam int OUT_W = 4 * DW;
	localparam int USER_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 63;
	localparam int FS_W = 42;
	localparam int ACC_W = 2 * DW;
	localparam int PH_W = 3;

	typedef logic [DW-1:0] word_t;
	typedef logic [PC_W-1:0] pc_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE = 2'd2;

	// Q24.40 constants
	localparam logic [CFG_DATA_W-1:0] INV_MASS_RST = 63'h100_0000_0000;
	localparam logic [FS_W-1:0] FORCE_SCALE_RST = 42'h100_0000_0000;
	localparam logic [ACC_W-1:0] ROUND_HALF = 128'h80_0000_0000;
	localparam word_t S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam word_t S64_MIN = 64'h8000_0000_0000_0000;

	// multiplier phases: 1..4 partial products, 2..5 accumulate, last one done
	localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PH_W-1:0] PH_DONE = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MUL,
		OP_ADD,
		OP_HALF,
		OP_SAVE
	} op_t;

	typedef enum logic [4:0] {
		SRC_ZERO,
		SRC_F,
		SRC_V,
		SRC_D,
		SRC_P0,
		SRC_IM,
		SRC_DT,
		SRC_FS,
		SRC_OV,
		SRC_OA,
		SRC_T0,
		SRC_T1,
		SRC_T2,
		SRC_T3,
		SRC_VEL,
		SRC_STEP,
		SRC_DOUT
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_T0,
		DST_T1,
		DST_T2,
		DST_T3,
		DST_VEL,
		DST_STEP,
		DST_DOUT
	} dst_t;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_FIXED,
		JC_CORRECT
	} jc_t;

	typedef struct packed {
		op_t  op;
		src_t sa;
		src_t sb;
		dst_t dst;
		jc_t  jc;
		pc_t  target;
		logic last;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   en;
		logic   mul_start;
		logic   load;
	} ctrl_t;

	// program entry points
	localparam pc_t PC_CORRECT = 5'd10;
	localparam pc_t PC_FIXED = 5'd27;
	localparam pc_t PC_FINISH = 5'd30;
	localparam pc_t PC_NONE = 5'd0;

	function automatic uword_t uw(op_t op, src_t sa, src_t sb, dst_t dst, jc_t jc, pc_t tgt,
			logic last);
		uword_t w;
		w = '{op: op, sa: sa, sb: sb, dst: dst, jc: jc, target: tgt, last: last};
		return w;
	endfunction

	// Microprogram. T0 = a, T1 = a*dt on the free paths.
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = uw(OP_NOP,  SRC_ZERO, SRC_ZERO, DST_NONE, JC_FIXED,   PC_FIXED,   1'b0);
			5'd1:  w = uw(OP_MUL,  SRC_F,    SRC_IM,   DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd2:  w = uw(OP_MUL,  SRC_T0,   SRC_DT,   DST_T1,   JC_CORRECT, PC_CORRECT, 1'b0);
			// predict, free axis
			5'd3:  w = uw(OP_SAVE, SRC_ZERO, SRC_ZERO, DST_NONE, JC_NEXT,    PC_NONE,    1'b0);
			5'd4:  w = uw(OP_MUL,  SRC_V,    SRC_DT,   DST_T2,   JC_NEXT,    PC_NONE,    1'b0);
			5'd5:  w = uw(OP_MUL,  SRC_T1,   SRC_DT,   DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd6:  w = uw(OP_HALF, SRC_T3,   SRC_ZERO, DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd7:  w = uw(OP_ADD,  SRC_T2,   SRC_T3,   DST_STEP, JC_NEXT,    PC_NONE,    1'b0);
			5'd8:  w = uw(OP_MUL,  SRC_FS,   SRC_T1,   DST_T2,   JC_NEXT,    PC_NONE,    1'b0);
			5'd9:  w = uw(OP_ADD,  SRC_V,    SRC_T2,   DST_VEL,  JC_ALWAYS,  PC_FINISH,  1'b0);
			// correct, free axis: T2 = oa*dt
			5'd10: w = uw(OP_MUL,  SRC_OA,   SRC_DT,   DST_T2,   JC_NEXT,    PC_NONE,    1'b0);
			5'd11: w = uw(OP_HALF, SRC_T2,   SRC_ZERO, DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd12: w = uw(OP_ADD,  SRC_OV,   SRC_T3,   DST_VEL,  JC_NEXT,    PC_NONE,    1'b0);
			5'd13: w = uw(OP_HALF, SRC_T1,   SRC_ZERO, DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd14: w = uw(OP_ADD,  SRC_VEL,  SRC_T3,   DST_VEL,  JC_NEXT,    PC_NONE,    1'b0);
			5'd15: w = uw(OP_MUL,  SRC_VEL,  SRC_DT,   DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd16: w = uw(OP_MUL,  SRC_T1,   SRC_DT,   DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd17: w = uw(OP_HALF, SRC_T0,   SRC_ZERO, DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd18: w = uw(OP_ADD,  SRC_T3,   SRC_T0,   DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd19: w = uw(OP_MUL,  SRC_OV,   SRC_DT,   DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd20: w = uw(OP_MUL,  SRC_T2,   SRC_DT,   DST_T1,   JC_NEXT,    PC_NONE,    1'b0);
			5'd21: w = uw(OP_HALF, SRC_T1,   SRC_ZERO, DST_T1,   JC_NEXT,    PC_NONE,    1'b0);
			5'd22: w = uw(OP_ADD,  SRC_T0,   SRC_T1,   DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd23: w = uw(OP_HALF, SRC_T3,   SRC_ZERO, DST_T3,   JC_NEXT,    PC_NONE,    1'b0);
			5'd24: w = uw(OP_HALF, SRC_T0,   SRC_ZERO, DST_T0,   JC_NEXT,    PC_NONE,    1'b0);
			5'd25: w = uw(OP_ADD,  SRC_T3,   SRC_T0,   DST_STEP, JC_NEXT,    PC_NONE,    1'b0);
			5'd26: w = uw(OP_ADD,  SRC_D,    SRC_STEP, DST_DOUT, JC_ALWAYS,  PC_FINISH,  1'b0);
			// fixed axis
			5'd27: w = uw(OP_NOP,  SRC_ZERO, SRC_ZERO, DST_NONE, JC_CORRECT, PC_FINISH,  1'b0);
			5'd28: w = uw(OP_MUL,  SRC_DT,   SRC_V,    DST_STEP, JC_NEXT,    PC_NONE,    1'b0);
			5'd29: w = uw(OP_ADD,  SRC_D,    SRC_STEP, DST_DOUT, JC_NEXT,    PC_NONE,    1'b0);
			// position and result
			5'd30: w = uw(OP_ADD,  SRC_P0,   SRC_DOUT, DST_NONE, JC_NEXT,    PC_NONE,    1'b1);
			default: w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JC_ALWAYS, PC_FINISH, 1'b0);
		endcase
		return w;
	endfunction

	function automatic word_t qadd(word_t a, word_t b);
		word_t s;
		s = a + b;
		if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1])
			return a[DW-1] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	// x * 0.5 rounded half away from zero
	function automatic word_t qhalf(word_t x);
		word_t m;
		logic [DW:0] h;
		m = x[DW-1] ? (~x + 64'd1) : x;
		h = {1'b0, m} + 65'd1;
		return x[DW-1] ? (~h[DW:1] + 64'd1) : h[DW:1];
	endfunction

endpackage

/* sv/tpc_mul.sv */
// Multi-cycle Q24.40 multiplier: four 32x32 partial products, rounding and saturation.
module tpc_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tpc_pkg::word_t       a,
	input  tpc_pkg::word_t       b,
	output logic                 done,
	output tpc_pkg::word_t       res
);

	logic [tpc_pkg::PH_W-1:0] ph_q;
	tpc_pkg::word_t ma_q, mb_q, pp_q;
	logic neg_q;
	logic [tpc_pkg::ACC_W-1:0] acc_q, pp_sh;
	logic [tpc_pkg::PH_W-1:0] ph_m1, ph_m2;
	logic [31:0] ap, bp;
	tpc_pkg::word_t prod, q, limit, qs;
	logic over;

	assign ph_m1 = ph_q - 3'd1;
	assign ph_m2 = ph_q - 3'd2;
	assign ap = ph_m1[1] ? ma_q[63:32] : ma_q[31:0];
	assign bp = ph_m1[0] ? mb_q[63:32] : mb_q[31:0];
	assign prod = {32'd0, ap} * {32'd0, bp};

	always_comb begin
		case (ph_m2[1:0])
			2'd0: pp_sh = {64'd0, pp_q};
			2'd3: pp_sh = {pp_q, 64'd0};
			default: pp_sh = {32'd0, pp_q, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= tpc_pkg::PH_IDLE;
		end else if (start) begin
			ph_q <= 3'd1;
		end else if (ph_q != tpc_pkg::PH_IDLE) begin
			ph_q <= (ph_q == tpc_pkg::PH_DONE) ? tpc_pkg::PH_IDLE : ph_q + 3'd1;
		end
	end

	// rounding constant preloaded into the accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? (~a + 64'd1) : a;
			mb_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= tpc_pkg::ROUND_HALF;
		end else begin
			if (ph_q >= 3'd1 && ph_q <= 3'd4)
				pp_q <= prod;
			if (ph_q >= 3'd2 && ph_q <= 3'd5)
				acc_q <= acc_q + pp_sh;
		end
	end

	always_comb begin
		q     = acc_q[103:40];
		over  = |acc_q[127:104];
		limit = neg_q ? tpc_pkg::S64_MIN : tpc_pkg::S64_MAX;
		qs    = (over || q > limit) ? limit : q;
		res   = neg_q ? (~qs + 64'd1) : qs;
	end

	assign done = (ph_q == tpc_pkg::PH_DONE);

endmodule

/* sv/tpc_dp.sv */
// Datapath: config registers, operand registers, saved axis state, ALU and multiplier.
module tpc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tpc_pkg::ctrl_t                    ctrl,
	input  logic [tpc_pkg::IN_W-1:0]          in_data,
	input  logic [1:0]                        in_axis,
	input  logic                              cfg_wr_en,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              mul_done,
	output logic [tpc_pkg::OUT_W-1:0]         out_data
);

	logic [tpc_pkg::CFG_DATA_W-1:0] inv_mass_q, time_step_q;
	logic [tpc_pkg::FS_W-1:0] force_scale_q;
	tpc_pkg::word_t f_q, v_q, d_q, p0_q;
	tpc_pkg::word_t t0_q, t1_q, t2_q, t3_q, vel_q, step_q, dout_q;
	tpc_pkg::word_t sv_q [tpc_pkg::AXES];
	tpc_pkg::word_t sa_q [tpc_pkg::AXES];
	logic [1:0] axis_q;
	logic axis_ok;
	tpc_pkg::word_t ov, oa, opa, opb, mul_res, wb;

	assign axis_ok = (axis_q < 2'(tpc_pkg::AXES));
	assign ov = axis_ok ? sv_q[axis_q] : '0;
	assign oa = axis_ok ? sa_q[axis_q] : '0;

	always_comb begin
		case (ctrl.uw.sa)
			tpc_pkg::SRC_F:    opa = f_q;
			tpc_pkg::SRC_V:    opa = v_q;
			tpc_pkg::SRC_D:    opa = d_q;
			tpc_pkg::SRC_P0:   opa = p0_q;
			tpc_pkg::SRC_IM:   opa = {1'b0, inv_mass_q};
			tpc_pkg::SRC_DT:   opa = {1'b0, time_step_q};
			tpc_pkg::SRC_FS:   opa = {22'd0, force_scale_q};
			tpc_pkg::SRC_OV:   opa = ov;
			tpc_pkg::SRC_OA:   opa = oa;
			tpc_pkg::SRC_T0:   opa = t0_q;
			tpc_pkg::SRC_T1:   opa = t1_q;
			tpc_pkg::SRC_T2:   opa = t2_q;
			tpc_pkg::SRC_T3:   opa = t3_q;
			tpc_pkg::SRC_VEL:  opa = vel_q;
			tpc_pkg::SRC_STEP: opa = step_q;
			tpc_pkg::SRC_DOUT: opa = dout_q;
			default:           opa = '0;
		endcase
	end

	always_comb begin
		case (ctrl.uw.sb)
			tpc_pkg::SRC_F:    opb = f_q;
			tpc_pkg::SRC_V:    opb = v_q;
			tpc_pkg::SRC_D:    opb = d_q;
			tpc_pkg::SRC_P0:   opb = p0_q;
			tpc_pkg::SRC_IM:   opb = {1'b0, inv_mass_q};
			tpc_pkg::SRC_DT:   opb = {1'b0, time_step_q};
			tpc_pkg::SRC_FS:   opb = {22'd0, force_scale_q};
			tpc_pkg::SRC_OV:   opb = ov;
			tpc_pkg::SRC_OA:   opb = oa;
			tpc_pkg::SRC_T0:   opb = t0_q;
			tpc_pkg::SRC_T1:   opb = t1_q;
			tpc_pkg::SRC_T2:   opb = t2_q;
			tpc_pkg::SRC_T3:   opb = t3_q;
			tpc_pkg::SRC_VEL:  opb = vel_q;
			tpc_pkg::SRC_STEP: opb = step_q;
			tpc_pkg::SRC_DOUT: opb = dout_q;
			default:           opb = '0;
		endcase
	end

	tpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.res    (mul_res)
	);

	always_comb begin
		case (ctrl.uw.op)
			tpc_pkg::OP_MUL:  wb = mul_res;
			tpc_pkg::OP_HALF: wb = tpc_pkg::qhalf(opa);
			default:          wb = tpc_pkg::qadd(opa, opb);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q    <= tpc_pkg::INV_MASS_RST;
			time_step_q   <= '0;
			force_scale_q <= tpc_pkg::FORCE_SCALE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tpc_pkg::CFG_INV_MASS:    inv_mass_q    <= cfg_data;
				tpc_pkg::CFG_TIME_STEP:   time_step_q   <= cfg_data;
				tpc_pkg::CFG_FORCE_SCALE: force_scale_q <= cfg_data[tpc_pkg::FS_W-1:0];
				default: ;
			endcase
		end
	end

	// saved velocity and acceleration, written by a free-axis predict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tpc_pkg::AXES; k++) begin
				sv_q[k] <= '0;
				sa_q[k] <= '0;
			end
		end else if (ctrl.en && ctrl.uw.op == tpc_pkg::OP_SAVE && axis_ok) begin
			sv_q[axis_q] <= v_q;
			sa_q[axis_q] <= t0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			f_q    <= in_data[63:0];
			v_q    <= in_data[127:64];
			d_q    <= in_data[191:128];
			p0_q   <= in_data[255:192];
			axis_q <= in_axis;
			vel_q  <= in_data[127:64];
			step_q <= '0;
			dout_q <= in_data[191:128];
		end else if (ctrl.en) begin
			case (ctrl.uw.dst)
				tpc_pkg::DST_T0:   t0_q   <= wb;
				tpc_pkg::DST_T1:   t1_q   <= wb;
				tpc_pkg::DST_T2:   t2_q   <= wb;
				tpc_pkg::DST_T3:   t3_q   <= wb;
				tpc_pkg::DST_VEL:  vel_q  <= wb;
				tpc_pkg::DST_STEP: step_q <= wb;
				tpc_pkg::DST_DOUT: dout_q <= wb;
				default: ;
			endcase
		end
	end

	// on the last step wb is initial_position + displacement_out
	assign out_data = {wb, dout_q, step_q, vel_q};

endmodule

/* sv/tpc_seq.sv */
// Microcode sequencer: step counter, conditional jumps and multiplier wait.
module tpc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            cmd,
	input  logic            fixed,
	input  logic            mul_done,
	input  logic            out_free,
	output tpc_pkg::ctrl_t  ctrl,
	output logic            busy,
	output logic            emit
);

	tpc_pkg::pc_t pc_q;
	logic run_q, corr_q, fixed_q, mwait_q;
	tpc_pkg::uword_t uw;
	logic adv, step_en, taken, mul_start;

	assign uw = tpc_pkg::ucode(pc_q);
	assign adv = (uw.op != tpc_pkg::OP_MUL) || mul_done;
	assign step_en = run_q && adv && (!uw.last || out_free);
	assign mul_start = run_q && (uw.op == tpc_pkg::OP_MUL) && !mwait_q;

	always_comb begin
		unique case (uw.jc)
			tpc_pkg::JC_ALWAYS:  taken = 1'b1;
			tpc_pkg::JC_FIXED:   taken = fixed_q;
			tpc_pkg::JC_CORRECT: taken = corr_q;
			default:             taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			run_q   <= 1'b0;
			corr_q  <= 1'b0;
			fixed_q <= 1'b0;
			mwait_q <= 1'b0;
		end else begin
			if (load) begin
				pc_q    <= '0;
				run_q   <= 1'b1;
				corr_q  <= cmd;
				fixed_q <= fixed;
			end else if (step_en) begin
				if (uw.last)
					run_q <= 1'b0;
				else
					pc_q <= taken ? uw.target : pc_q + 5'd1;
			end
			if (mul_start)
				mwait_q <= 1'b1;
			else if (mul_done)
				mwait_q <= 1'b0;
		end
	end

	assign ctrl = '{uw: uw, en: step_en, mul_start: mul_start, load: load};
	assign busy = run_q;
	assign emit = step_en && uw.last;

endmodule

/* sv/translational_predictor_corrector.sv */
// A new request is taken the cycle after the previous one ends. The rate is set by the
// single shared 32x32 multiplier: each Q24.40 product is built from four partial products,
// accumulated with rounding, then saturated; other microcode steps do not wait on it.
// Reset (arst_n low, async): sequencer idle, output empty, saved axis state zero,
// inv_mass and force_scale 1.0, time_step 0.
module translational_predictor_corrector (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// force_in, velocity_in, displacement_in, initial_position (64 bits each)
	input  logic [tpc_pkg::IN_W-1:0]           s_tdata,
	// cmd[0], axis[2:1], axis_fixed[3]
	input  logic [tpc_pkg::USER_W-1:0]         s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// velocity_out, displacement_step, displacement_out, position_out (64 bits each)
	output logic [tpc_pkg::OUT_W-1:0]          m_tdata,
	// register write port
	input  logic                               cfg_wr_en,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tpc_pkg::ctrl_t ctrl;
	logic busy, emit, accept, out_free, mul_done;
	logic [tpc_pkg::OUT_W-1:0] dp_out;
	logic m_tvalid_q;
	logic [tpc_pkg::OUT_W-1:0] m_tdata_q;

	// one request in flight; the output register lets the next start while a result waits
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	tpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.cmd      (s_tuser[0]),
		.fixed    (s_tuser[3]),
		.mul_done (mul_done),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (busy),
		.emit     (emit)
	);

	tpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_data   (s_tdata),
		.in_axis   (s_tuser[2:1]),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mul_done  (mul_done),
		.out_data  (dp_out)
	);

	// result register; the last microcode step stalls until it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			m_tdata_q <= dp_out;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
